FILE: rtl/core/sha512_pkg.sv
// SHA-512 package: controller state type, datapath command struct, round constants,
// initial hash values and a rotate-right helper. No dependencies.
`default_nettype none
package sha512_pkg;

    localparam int WordWidth   = 64;
    localparam int BlockWords  = 16;
    localparam int NumRounds   = 80;
    localparam int DigestWords = 8;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_FINISH,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic       load_word;
        logic       init_hash;
        logic       start_rounds;
        logic       do_round;
        logic [6:0] round;
        logic       finish;
        logic [2:0] emit_sel;
    } dp_cmd_t;

    function automatic logic [63:0] round_k(input logic [6:0] idx);
        logic [63:0] k;
        case (idx)
            7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] init_hash(input logic [2:0] idx);
        logic [63:0] h;
        case (idx)
            3'd0: h = 64'h6a09e667f3bcc908;
            3'd1: h = 64'hbb67ae8584caa73b;
            3'd2: h = 64'h3c6ef372fe94f82b;
            3'd3: h = 64'ha54ff53a5f1d36f1;
            3'd4: h = 64'h510e527fade682d1;
            3'd5: h = 64'h9b05688c2b3e6c1f;
            3'd6: h = 64'h1f83d9abfb41bd6b;
            default: h = 64'h5be0cd19137e2179;
        endcase
        return h;
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sha512_ctrl.sv
// SHA-512 controller: block word count, round sequencing and digest emission.
// Depends on sha512_pkg.
`default_nettype none
module sha512_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             first_of_message,
    input  wire logic             final_block,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [2:0]            out_index,
    output sha512_pkg::dp_cmd_t   cmd
);
    sha512_pkg::ctrl_state_t state_reg, state_next;
    logic [3:0] word_reg, word_next;
    logic [6:0] round_reg, round_next;
    logic [2:0] emit_reg, emit_next;
    logic       final_reg, final_next;
    logic       in_acc;

    assign in_acc = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha512_pkg::ST_LOAD;
            word_reg  <= '0;
            round_reg <= '0;
            emit_reg  <= '0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
            round_reg <= round_next;
            emit_reg  <= emit_next;
            final_reg <= final_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        round_next = round_reg;
        emit_next  = emit_reg;
        final_next = final_reg;
        case (state_reg)
            sha512_pkg::ST_LOAD:
            begin
                if (in_acc)
                begin
                    word_next = word_reg + 4'd1;
                    if (word_reg == 4'(sha512_pkg::BlockWords - 1))
                    begin
                        final_next = final_block;
                        round_next = '0;
                        state_next = sha512_pkg::ST_ROUND;
                    end
                end
            end
            sha512_pkg::ST_ROUND:
            begin
                round_next = round_reg + 7'd1;
                if (round_reg == 7'(sha512_pkg::NumRounds - 1))
                    state_next = sha512_pkg::ST_FINISH;
            end
            sha512_pkg::ST_FINISH:
            begin
                emit_next  = '0;
                state_next = final_reg ? sha512_pkg::ST_EMIT : sha512_pkg::ST_LOAD;
            end
            sha512_pkg::ST_EMIT:
            begin
                if (out_ready)
                begin
                    emit_next = emit_reg + 3'd1;
                    if (emit_reg == 3'(sha512_pkg::DigestWords - 1))
                        state_next = sha512_pkg::ST_LOAD;
                end
            end
            default: state_next = sha512_pkg::ST_LOAD;
        endcase
    end

    always_comb
    begin
        in_ready         = (state_reg == sha512_pkg::ST_LOAD);
        out_valid        = (state_reg == sha512_pkg::ST_EMIT);
        out_index        = emit_reg;
        cmd.load_word    = in_acc;
        cmd.init_hash    = in_acc && (word_reg == '0) && first_of_message;
        cmd.start_rounds = in_acc && (word_reg == 4'(sha512_pkg::BlockWords - 1));
        cmd.do_round     = (state_reg == sha512_pkg::ST_ROUND);
        cmd.round        = round_reg;
        cmd.finish       = (state_reg == sha512_pkg::ST_FINISH);
        cmd.emit_sel     = emit_reg;
    end
endmodule
`default_nettype wire

FILE: rtl/core/sha512_datapath.sv
// SHA-512 datapath: 16-word schedule shift window, working variables, hash words.
// Depends on sha512_pkg.
`default_nettype none
module sha512_datapath (
    input  wire logic                clk,
    input  wire sha512_pkg::dp_cmd_t cmd,
    input  wire logic [63:0]         message_word,
    output logic [63:0]              digest_word
);
    logic [63:0] w_reg [16];
    logic [63:0] v_reg [8];
    logic [63:0] h_reg [8];
    logic [63:0] w_cur, w_new, s0, s1, big0, big1, chs, maj, t1, t2;

    always_comb
    begin
        s0    = sha512_pkg::rotr(w_reg[1], 1) ^ sha512_pkg::rotr(w_reg[1], 8)
                ^ (w_reg[1] >> 7);
        s1    = sha512_pkg::rotr(w_reg[14], 19) ^ sha512_pkg::rotr(w_reg[14], 61)
                ^ (w_reg[14] >> 6);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = w_reg[0];
        big1  = sha512_pkg::rotr(v_reg[4], 14) ^ sha512_pkg::rotr(v_reg[4], 18)
                ^ sha512_pkg::rotr(v_reg[4], 41);
        chs   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        big0  = sha512_pkg::rotr(v_reg[0], 28) ^ sha512_pkg::rotr(v_reg[0], 34)
                ^ sha512_pkg::rotr(v_reg[0], 39);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + big1 + chs + sha512_pkg::round_k(cmd.round) + w_cur;
        t2    = big0 + maj;
    end

    // window holds w[t..t+15]; w[0] is the current round word
    always_ff @(posedge clk)
    begin
        if (cmd.load_word || cmd.do_round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= cmd.load_word ? message_word : w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_rounds)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= cmd.init_hash ? sha512_pkg::init_hash(3'(i)) : h_reg[i];
        end
        else if (cmd.do_round)
        begin
            for (int i = 1; i < 8; i++)
                v_reg[i] <= v_reg[i - 1];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_hash)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= sha512_pkg::init_hash(3'(i));
        end
        else if (cmd.finish)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= h_reg[i] + v_reg[i];
        end
    end

    assign digest_word = h_reg[cmd.emit_sel];
endmodule
`default_nettype wire

FILE: rtl/core/sha512_block_hash.sv
// SHA-512 block hasher: takes sixteen 64-bit words per padded block on in_valid/in_ready
// and, after a block marked final, delivers eight digest words on out_valid/out_ready.
// A block is taken in word by word, then runs 80 rounds (one round per cycle through a
// single shared round unit), is folded into the hash words and, when final, its digest
// words are sent out; input is held off meanwhile.
`default_nettype none
module sha512_block_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] message_word,
    input  wire logic        first_of_message,
    input  wire logic        final_block,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      digest_word,
    output logic [2:0]       digest_index,
    output logic             digest_last
);
    sha512_pkg::dp_cmd_t cmd;
    logic                first_eff;
    logic                seen_reg;

    // after reset the hash words start from the initial values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 1'b0;
        else if (in_valid && in_ready)
            seen_reg <= 1'b1;
    end
    assign first_eff = first_of_message || !seen_reg;

    sha512_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .first_of_message (first_eff),
        .final_block      (final_block),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_index        (digest_index),
        .cmd              (cmd)
    );

    sha512_datapath u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .message_word (message_word),
        .digest_word  (digest_word)
    );

    assign digest_last = (digest_index == 3'(sha512_pkg::DigestWords - 1));
endmodule
`default_nettype wire

FILE: dv/sha512_block_hash_tb.sv
// Self-checking testbench for sha512_block_hash: streams 1024-bit blocks and
// compares every digest word against an in-bench SHA-512 predictor.
// Depends on rtl/core/sha512_pkg.sv (block, round and digest counts) and rtl/core/sha512_block_hash.sv.
`default_nettype none
module sha512_block_hash_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] word;
        logic        first;
        logic        final_flag;
    } msg_item_t;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_item_t;

    localparam int WatchdogLimit = 4000;

    localparam logic [63:0] ROUND_K [sha512_pkg::NumRounds] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [63:0] IV [sha512_pkg::DigestWords] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] message_word = '0;
    logic        first_of_message = 1'b0;
    logic        final_block = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;

    msg_item_t    pending_words[$];
    digest_item_t expected_digest[$];
    logic [63:0]  chain_hash[sha512_pkg::DigestWords];
    logic [63:0]  block_buf[sha512_pkg::BlockWords];
    int           word_pos = 0;
    int           error_count = 0;
    int           idle_cycles = 0;
    int           in_gap = 0;
    int           out_gap = 0;
    int           blocks_left = 7;
    bit           quiet_phase = 1'b0;
    bit           hold_sender = 1'b0;

    // registered view of the handshake seen at the last rising edge
    logic in_ready_q = 1'b0;

    sha512_block_hash dut (.*);

    always #6 clk = ~clk;

    function automatic logic [63:0] ror64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic compress_into_chain();
        logic [63:0] sched[sha512_pkg::NumRounds];
        logic [63:0] v[8];
        logic [63:0] t1, t2;
        for (int r = 0; r < sha512_pkg::NumRounds; r++)
        begin
            if (r < sha512_pkg::BlockWords)
                sched[r] = block_buf[r];
            else
                sched[r] = sched[r-16]
                    + (ror64(sched[r-15], 1) ^ ror64(sched[r-15], 8) ^ (sched[r-15] >> 7))
                    + sched[r-7]
                    + (ror64(sched[r-2], 19) ^ ror64(sched[r-2], 61) ^ (sched[r-2] >> 6));
        end
        for (int i = 0; i < 8; i++)
            v[i] = chain_hash[i];
        for (int r = 0; r < sha512_pkg::NumRounds; r++)
        begin
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + sched[r];
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_hash[i] = chain_hash[i] + v[i];
    endtask

    task automatic predict_digest(msg_item_t it);
        digest_item_t d;
        if (word_pos == 0 && it.first)
            for (int i = 0; i < 8; i++)
                chain_hash[i] = IV[i];
        block_buf[word_pos] = it.word;
        if (word_pos < sha512_pkg::BlockWords - 1)
        begin
            word_pos++;
            return;
        end
        word_pos = 0;
        compress_into_chain();
        if (!it.final_flag)
            return;
        for (int i = 0; i < 8; i++)
        begin
            d.word = chain_hash[i];
            d.index = 3'(i);
            d.last = (i == 7);
            expected_digest.push_back(d);
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic push_word(logic [63:0] w, logic f, logic fin);
        msg_item_t it;
        it.word = w;
        it.first = f;
        it.final_flag = fin;
        pending_words.push_back(it);
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // stray flags on inner words must be ignored
    task automatic push_block(logic f, logic fin, bit stray);
        for (int i = 0; i < sha512_pkg::BlockWords; i++)
            push_word(rand64(), (i == 0) ? f : (stray ? 1'($urandom()) : 1'b0),
                (i == sha512_pkg::BlockWords - 1) ? fin : (stray ? 1'($urandom()) : 1'b0));
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_digest.size() != 0)
            @(posedge clk);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready_q)
                pending_words.pop_front();
            if (in_valid && !in_ready_q)
                ;
            else if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 15) == 0)
            begin
                in_gap <= $urandom_range(1, 19);
                in_valid <= 1'b0;
            end
            else if (hold_sender || pending_words.size() == 0)
                in_valid <= 1'b0;
            else
            begin
                in_valid <= 1'b1;
                message_word <= pending_words[0].word;
                first_of_message <= pending_words[0].first;
                final_block <= pending_words[0].final_flag;
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                out_gap <= $urandom_range(1, 19);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        digest_item_t want;
        in_ready_q <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_digest(pending_words[0]);
            if (out_valid && out_ready)
            begin
                if (expected_digest.size() == 0)
                begin
                    report_mismatch("unexpected digest word", digest_word, '0);
                end
                else
                begin
                    want = expected_digest.pop_front();
                    if (digest_word !== want.word)
                        report_mismatch("digest_word", digest_word, want.word);
                    if (digest_index !== want.index)
                        report_mismatch("digest_index", 64'(digest_index), 64'(want.index));
                    if (digest_last !== want.last)
                        report_mismatch("digest_last", 64'(digest_last), 64'(want.last));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 8; i++)
            chain_hash[i] = IV[i];
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // no start flag on the first block: hashing starts from the initial values after reset
        push_block(1'b0, 1'b1, 1'b0);
        // extremes: an all-ones block, then an all-zero block with stray flags on inner words
        for (int i = 0; i < sha512_pkg::BlockWords; i++)
            push_word('1, (i == 0), (i == sha512_pkg::BlockWords - 1));
        for (int i = 0; i < sha512_pkg::BlockWords; i++)
            push_word('0, (i != 0), (i != sha512_pkg::BlockWords - 1));
        push_block(1'b0, 1'b1, 1'b1);
        wait_drained();
        hold_sender = 1'b1;
        repeat (20) @(posedge clk);
        hold_sender = 1'b0;
        while (blocks_left > 0)
        begin
            int nblk;
            nblk = $urandom_range(1, 3);
            if (nblk > blocks_left)
                nblk = blocks_left;
            for (int b = 0; b < nblk; b++)
                push_block((b == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 5) == 0),
                    b == nblk - 1, $urandom_range(0, 3) == 0);
            blocks_left -= nblk;
            if (blocks_left <= 3)
                quiet_phase = 1'b1;
            wait_drained();
        end
        wait_drained();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
